// ===== rtl/core/omw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package omw_pkg;

  localparam int unsigned N_WHEELS = 4;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned DEN_W    = 35;
  localparam int unsigned Q_W      = 33;
  localparam int unsigned RES_W    = 32;

  localparam logic [18:0]      TWO_PI_Q16 = 19'd411775;
  localparam logic [16:0]      W_S2H      = 17'd46341;
  localparam logic [16:0]      W_S3H      = 17'd56756;
  localparam logic [CFG_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [CFG_W-1:0] DIAM_RST   = 16'd512;

  localparam int unsigned WHL_FR = 0;
  localparam int unsigned WHL_FL = 1;
  localparam int unsigned WHL_BR = 2;
  localparam int unsigned WHL_BL = 3;

  typedef enum logic [1:0] {
    DRIVE_OMNI3,
    DRIVE_OMNI4,
    DRIVE_MECANUM
  } drive_t;

  typedef enum logic [1:0] {
    CFG_DRIVE_TYPE,
    CFG_WHL_RAD,
    CFG_BASE_DIAM
  } cfg_idx_t;

  typedef enum logic [2:0] {
    WK_ZERO,
    WK_ONE,
    WK_HALF,
    WK_S2H,
    WK_S3H
  } wkind_t;

  typedef struct packed {
    logic   neg;
    wkind_t kind;
  } weight_t;

  typedef struct packed {
    logic                fault;
    logic [N_WHEELS-1:0] act;
    logic [N_WHEELS-1:0] neg;
  } side_t;

  localparam weight_t WX_TAB [3][N_WHEELS] = '{
    '{'{1'b1, WK_ONE}, '{1'b0, WK_HALF}, '{1'b0, WK_HALF}, '{1'b0, WK_ZERO}},
    '{'{1'b1, WK_S2H}, '{1'b0, WK_S2H},  '{1'b0, WK_S2H},  '{1'b1, WK_S2H}},
    '{'{1'b0, WK_S2H}, '{1'b1, WK_S2H},  '{1'b1, WK_S2H},  '{1'b0, WK_S2H}}
  };

  localparam weight_t WY_TAB [3][N_WHEELS] = '{
    '{'{1'b0, WK_ZERO}, '{1'b1, WK_S3H}, '{1'b0, WK_S3H}, '{1'b0, WK_ZERO}},
    '{'{1'b0, WK_S2H},  '{1'b0, WK_S2H}, '{1'b1, WK_S2H}, '{1'b1, WK_S2H}},
    '{'{1'b1, WK_S2H},  '{1'b1, WK_S2H}, '{1'b0, WK_S2H}, '{1'b0, WK_S2H}}
  };

  function automatic weight_t x_weight(input logic [1:0] drive, input logic [1:0] wheel);
    weight_t w;
    w = '{neg: 1'b0, kind: WK_ZERO};
    if (drive <= DRIVE_MECANUM) begin
      w = WX_TAB[drive][wheel];
    end
    return w;
  endfunction

  function automatic weight_t y_weight(input logic [1:0] drive, input logic [1:0] wheel);
    weight_t w;
    w = '{neg: 1'b0, kind: WK_ZERO};
    if (drive <= DRIVE_MECANUM) begin
      w = WY_TAB[drive][wheel];
    end
    return w;
  endfunction

  function automatic logic [N_WHEELS-1:0] rot_mask(input logic [1:0] drive);
    logic [N_WHEELS-1:0] m;
    unique case (drive)
      DRIVE_OMNI3: begin
        m = '1;
        m[WHL_BL] = 1'b0;
      end
      DRIVE_OMNI4, DRIVE_MECANUM: m = '1;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/omw_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none

module omw_mix #(
  parameter int unsigned IN_WIDTH = 16
) (
  input  wire                                                  clk,
  input  wire                                                  rst_n,
  input  wire  [1:0]                                           drive_type,
  input  wire  [omw_pkg::CFG_W-1:0]                            whl_rad,
  input  wire  [omw_pkg::CFG_W-1:0]                            base_diam,
  input  wire  [omw_pkg::DEN_W-1:0]                            den,
  input  wire                                                  up_vld,
  output logic                                                 up_rdy,
  input  wire  signed [IN_WIDTH-1:0]                           vel_x,
  input  wire  signed [IN_WIDTH-1:0]                           vel_y,
  input  wire  signed [IN_WIDTH-1:0]                           vel_rot,
  output logic                                                 dn_vld,
  input  wire                                                  dn_rdy,
  output logic [omw_pkg::N_WHEELS-1:0][IN_WIDTH+39:0]          dn_rem,
  output omw_pkg::side_t                                       dn_side
);
  import omw_pkg::*;

  localparam int unsigned P_W   = IN_WIDTH + 17;
  localparam int unsigned NUM_W = IN_WIDTH + 24;
  localparam int unsigned MAG_W = NUM_W - 1;
  localparam int unsigned REM_W = IN_WIDTH + 40;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [P_W-1:0]      px2_r, py2_r, py3_r, rot1_r;
  logic signed [IN_WIDTH-1:0] vx1_r;
  logic [1:0]                 drv1_r;
  side_t                      side1_r, side2_r, side3_r, side4_r;

  logic signed [NUM_W-1:0] num2_r [N_WHEELS];
  logic [MAG_W-1:0]        mag3_r [N_WHEELS];
  logic [N_WHEELS-1:0][REM_W-1:0] rem4_r;

  logic signed [P_W-1:0]   px2_nxt, py2_nxt, py3_nxt, rot1_nxt;
  side_t                   side1_nxt, side3_nxt;
  logic signed [NUM_W-1:0] num2_nxt [N_WHEELS];
  logic [MAG_W-1:0]        mag3_nxt [N_WHEELS];
  logic [N_WHEELS-1:0][REM_W-1:0] rem4_nxt;

  assign rdy4   = !v4_r || dn_rdy;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign up_rdy = rdy1;

  assign px2_nxt  = P_W'($signed(W_S2H)) * P_W'(vel_x);
  assign py2_nxt  = P_W'($signed(W_S2H)) * P_W'(vel_y);
  assign py3_nxt  = P_W'($signed(W_S3H)) * P_W'(vel_y);
  assign rot1_nxt = P_W'($signed({1'b0, base_diam})) * P_W'(vel_rot);

  always_comb begin
    side1_nxt.fault = (whl_rad == '0);
    side1_nxt.act   = rot_mask(drive_type) & {N_WHEELS{!side1_nxt.fault}};
    side1_nxt.neg   = '0;
  end

  always_comb begin
    weight_t                 wx;
    weight_t                 wy;
    logic signed [NUM_W-1:0] tx;
    logic signed [NUM_W-1:0] ty;
    for (int w = 0; w < N_WHEELS; w++) begin
      wx = x_weight(drv1_r, 2'(w));
      wy = y_weight(drv1_r, 2'(w));
      unique case (wx.kind)
        WK_ONE:  tx = NUM_W'(vx1_r) <<< 16;
        WK_HALF: tx = NUM_W'(vx1_r) <<< 15;
        WK_S2H:  tx = NUM_W'(px2_r);
        default: tx = '0;
      endcase
      unique case (wy.kind)
        WK_S2H:  ty = NUM_W'(py2_r);
        WK_S3H:  ty = NUM_W'(py3_r);
        default: ty = '0;
      endcase
      if (wx.neg) begin
        tx = -tx;
      end
      if (wy.neg) begin
        ty = -ty;
      end
      num2_nxt[w] = tx + ty + (NUM_W'(rot1_r) <<< 7);
    end
  end

  always_comb begin
    side3_nxt = side2_r;
    for (int w = 0; w < N_WHEELS; w++) begin
      side3_nxt.neg[w] = num2_r[w][NUM_W-1];
      mag3_nxt[w] = num2_r[w][NUM_W-1] ? MAG_W'(-num2_r[w]) : MAG_W'(num2_r[w]);
    end
  end

  always_comb begin
    for (int w = 0; w < N_WHEELS; w++) begin
      rem4_nxt[w] = REM_W'({mag3_r[w], 16'b0}) + REM_W'(den >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_vld;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_vld) begin
      px2_r   <= px2_nxt;
      py2_r   <= py2_nxt;
      py3_r   <= py3_nxt;
      rot1_r  <= rot1_nxt;
      vx1_r   <= vel_x;
      drv1_r  <= drive_type;
      side1_r <= side1_nxt;
    end
    if (rdy2 && v1_r) begin
      num2_r  <= num2_nxt;
      side2_r <= side1_r;
    end
    if (rdy3 && v2_r) begin
      mag3_r  <= mag3_nxt;
      side3_r <= side3_nxt;
    end
    if (rdy4 && v3_r) begin
      rem4_r  <= rem4_nxt;
      side4_r <= side3_r;
    end
  end

  assign dn_vld  = v4_r;
  assign dn_rem  = rem4_r;
  assign dn_side = side4_r;

endmodule

`default_nettype wire

// ===== rtl/core/omw_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module omw_div_stage #(
  parameter int unsigned IN_WIDTH = 16,
  parameter int unsigned BIT      = 0
) (
  input  wire                                                clk,
  input  wire                                                rst_n,
  input  wire  [omw_pkg::DEN_W-1:0]                          den,
  input  wire                                                up_vld,
  output logic                                               up_rdy,
  input  wire  [omw_pkg::N_WHEELS-1:0][IN_WIDTH+39:0]        up_rem,
  input  wire  [omw_pkg::N_WHEELS-1:0][omw_pkg::Q_W-1:0]     up_q,
  input  wire  omw_pkg::side_t                               up_side,
  output logic                                               dn_vld,
  input  wire                                                dn_rdy,
  output logic [omw_pkg::N_WHEELS-1:0][IN_WIDTH+39:0]        dn_rem,
  output logic [omw_pkg::N_WHEELS-1:0][omw_pkg::Q_W-1:0]     dn_q,
  output omw_pkg::side_t                                     dn_side
);
  import omw_pkg::*;

  localparam int unsigned REM_W = IN_WIDTH + 40;
  localparam int unsigned CMP_W = (REM_W > DEN_W + Q_W) ? REM_W : DEN_W + Q_W;

  logic                           vld_r;
  logic [N_WHEELS-1:0][REM_W-1:0] rem_r;
  logic [N_WHEELS-1:0][Q_W-1:0]   q_r;
  side_t                          side_r;

  logic [CMP_W-1:0]               div_sh;
  logic [N_WHEELS-1:0][REM_W-1:0] rem_nxt;
  logic [N_WHEELS-1:0][Q_W-1:0]   q_nxt;

  assign up_rdy = !vld_r || dn_rdy;
  assign div_sh = CMP_W'(den) << BIT;

  always_comb begin
    logic [CMP_W-1:0] rem_x;
    rem_nxt = up_rem;
    q_nxt   = up_q;
    for (int w = 0; w < N_WHEELS; w++) begin
      rem_x = CMP_W'(up_rem[w]);
      if (rem_x >= div_sh) begin
        rem_nxt[w]  = REM_W'(rem_x - div_sh);
        q_nxt[w][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      side_r <= up_side;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_rem  = rem_r;
  assign dn_q    = q_r;
  assign dn_side = side_r;

endmodule

`default_nettype wire

// ===== rtl/core/omw_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module omw_out (
  input  wire                                                clk,
  input  wire                                                rst_n,
  input  wire                                                up_vld,
  output logic                                               up_rdy,
  input  wire  [omw_pkg::N_WHEELS-1:0][omw_pkg::Q_W-1:0]     up_q,
  input  wire  omw_pkg::side_t                               up_side,
  output logic                                               dn_vld,
  input  wire                                                dn_stall,
  output logic [omw_pkg::N_WHEELS-1:0][omw_pkg::RES_W-1:0]   dn_speed,
  output logic                                               dn_fault
);
  import omw_pkg::*;

  localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};

  logic                           vld_r;
  logic [N_WHEELS-1:0][RES_W-1:0] speed_r;
  logic                           fault_r;
  logic [N_WHEELS-1:0][RES_W-1:0] speed_nxt;

  assign up_rdy = !vld_r || !dn_stall;

  always_comb begin
    logic [RES_W-1:0] mag;
    for (int w = 0; w < N_WHEELS; w++) begin
      mag = up_q[w][RES_W-1:0];
      if (!up_side.act[w]) begin
        speed_nxt[w] = '0;
      end else if (up_side.neg[w]) begin
        speed_nxt[w] = (up_q[w][Q_W-1] || (mag > SAT_NEG)) ? SAT_NEG : -mag;
      end else begin
        speed_nxt[w] = (up_q[w][Q_W-1] || mag[RES_W-1]) ? SAT_POS : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      speed_r <= speed_nxt;
      fault_r <= up_side.fault;
    end
  end

  assign dn_vld   = vld_r;
  assign dn_speed = speed_r;
  assign dn_fault = fault_r;

endmodule

`default_nettype wire

// ===== rtl/core/omni_mecanum_wheel_speeds.sv =====
// Body velocity command (x, y, rotation, signed Q8.8) in, four wheel speeds (signed Q16.16,
// rounded to nearest with ties away from zero, saturated) out, for a three-wheel omni,
// four-wheel omni or mecanum base. One command is taken every cycle unless out_stall backs
// up the pipeline and raises in_stall; four stages form the weighted mix and the
// rounding offset, 33 stages run a restoring divide by 2*pi times the wheel radius one
// quotient bit per stage for all four wheels at once, and one stage saturates into the
// output register. The divisor is formed when the wheel radius is written, so change the
// registers only while no command is in flight. A zero wheel radius forces all speeds to
// zero and sets radius_fault; back_left is zero in three-wheel mode and every speed is
// zero for the unused drive type code.
`timescale 1ns / 1ps
`default_nettype none

module omni_mecanum_wheel_speeds #(
  parameter int unsigned IN_WIDTH = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire  [1:0]                 cfg_idx,
  input  wire  [omw_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  signed [IN_WIDTH-1:0] in_vel_x,
  input  wire  signed [IN_WIDTH-1:0] in_vel_y,
  input  wire  signed [IN_WIDTH-1:0] in_vel_rot,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [31:0]         out_front_right,
  output logic signed [31:0]         out_front_left,
  output logic signed [31:0]         out_back_right,
  output logic signed [31:0]         out_back_left,
  output logic                       out_radius_fault
);
  import omw_pkg::*;

  localparam int unsigned REM_W = IN_WIDTH + 40;

  logic [1:0]       drive_type_r;
  logic [CFG_W-1:0] whl_rad_r;
  logic [CFG_W-1:0] base_diam_r;
  logic [DEN_W-1:0] den_r;

  logic                           mix_rdy;
  logic [Q_W:0]                   stg_vld;
  logic [Q_W:0]                   stg_rdy;
  logic [N_WHEELS-1:0][REM_W-1:0] stg_rem  [Q_W+1];
  logic [N_WHEELS-1:0][Q_W-1:0]   stg_q    [Q_W+1];
  side_t                          stg_side [Q_W+1];

  logic [N_WHEELS-1:0][RES_W-1:0] speed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_type_r <= DRIVE_OMNI4;
      whl_rad_r    <= RADIUS_RST;
      base_diam_r  <= DIAM_RST;
      den_r        <= DEN_W'(TWO_PI_Q16) * DEN_W'(RADIUS_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DRIVE_TYPE: drive_type_r <= cfg_wdata[1:0];
        CFG_WHL_RAD: begin
          whl_rad_r <= cfg_wdata;
          den_r     <= DEN_W'(TWO_PI_Q16) * DEN_W'(cfg_wdata);
        end
        CFG_BASE_DIAM: base_diam_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = !mix_rdy;
  assign stg_q[0] = '0;

  omw_mix #(
    .IN_WIDTH (IN_WIDTH)
  ) u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .drive_type (drive_type_r),
    .whl_rad    (whl_rad_r),
    .base_diam  (base_diam_r),
    .den        (den_r),
    .up_vld     (in_valid),
    .up_rdy     (mix_rdy),
    .vel_x      (in_vel_x),
    .vel_y      (in_vel_y),
    .vel_rot    (in_vel_rot),
    .dn_vld     (stg_vld[0]),
    .dn_rdy     (stg_rdy[0]),
    .dn_rem     (stg_rem[0]),
    .dn_side    (stg_side[0])
  );

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    omw_div_stage #(
      .IN_WIDTH (IN_WIDTH),
      .BIT      (Q_W - 1 - g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .den     (den_r),
      .up_vld  (stg_vld[g]),
      .up_rdy  (stg_rdy[g]),
      .up_rem  (stg_rem[g]),
      .up_q    (stg_q[g]),
      .up_side (stg_side[g]),
      .dn_vld  (stg_vld[g+1]),
      .dn_rdy  (stg_rdy[g+1]),
      .dn_rem  (stg_rem[g+1]),
      .dn_q    (stg_q[g+1]),
      .dn_side (stg_side[g+1])
    );
  end

  omw_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (stg_vld[Q_W]),
    .up_rdy   (stg_rdy[Q_W]),
    .up_q     (stg_q[Q_W]),
    .up_side  (stg_side[Q_W]),
    .dn_vld   (out_valid),
    .dn_stall (out_stall),
    .dn_speed (speed),
    .dn_fault (out_radius_fault)
  );

  assign out_front_right = $signed(speed[WHL_FR]);
  assign out_front_left  = $signed(speed[WHL_FL]);
  assign out_back_right  = $signed(speed[WHL_BR]);
  assign out_back_left   = $signed(speed[WHL_BL]);

  a_empty_out_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  a_fault_zero_speeds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_radius_fault |->
      out_front_right == '0 && out_front_left == '0 &&
      out_back_right == '0 && out_back_left == '0)
    else $error("nonzero wheel speed with radius fault");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stg_vld[Q_W]))
    else $error("result appeared without an item in the last divide stage");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

import omw_pkg::*;

typedef struct packed {
  logic signed [31:0] fr;
  logic signed [31:0] fl;
  logic signed [31:0] br;
  logic signed [31:0] bl;
  logic               fault;
} wheel_speeds_t;

class wheel_speed_board;
  localparam longint W_ONE  = 65536;
  localparam longint W_HALF = 32768;
  localparam longint S2H    = longint'(W_S2H);
  localparam longint S3H    = longint'(W_S3H);

  logic [1:0]    drive;
  logic [15:0]   radius;
  logic [15:0]   diameter;
  wheel_speeds_t speeds_due[$];
  int            mismatches;

  function new();
    drive      = DRIVE_OMNI4;
    radius     = RADIUS_RST;
    diameter   = DIAM_RST;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      CFG_DRIVE_TYPE: drive = data[1:0];
      CFG_WHL_RAD:    radius = data;
      CFG_BASE_DIAM:  diameter = data;
      default: ;
    endcase
  endfunction

  function longint x_gain(logic [1:0] drv, int wheel);
    longint g;
    g = 0;
    case (drv)
      DRIVE_OMNI3:   g = (wheel == WHL_FR) ? -W_ONE : (wheel == WHL_BL) ? 0 : W_HALF;
      DRIVE_OMNI4:   g = (wheel == WHL_FR || wheel == WHL_BL) ? -S2H : S2H;
      DRIVE_MECANUM: g = (wheel == WHL_FR || wheel == WHL_BL) ? S2H : -S2H;
      default:       g = 0;
    endcase
    return g;
  endfunction

  function longint y_gain(logic [1:0] drv, int wheel);
    longint g;
    g = 0;
    case (drv)
      DRIVE_OMNI3:   g = (wheel == WHL_FL) ? -S3H : (wheel == WHL_BR) ? S3H : 0;
      DRIVE_OMNI4:   g = (wheel == WHL_FR || wheel == WHL_FL) ? S2H : -S2H;
      DRIVE_MECANUM: g = (wheel == WHL_FR || wheel == WHL_FL) ? -S2H : S2H;
      default:       g = 0;
    endcase
    return g;
  endfunction

  function logic [31:0] div_round_sat(longint num, longint unsigned den);
    bit              neg;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned r;
    longint unsigned res;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    q = mag / den;
    r = mag % den;
    if (q > 64'd32768) begin
      res = 64'h1_0000_0000;
    end else begin
      res = (q << 16) + ((r << 16) + den / 2) / den;
    end
    if (neg) begin
      if (res > 64'h8000_0000) res = 64'h8000_0000;
      res = 64'd0 - res;
      return res[31:0];
    end
    if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
    return res[31:0];
  endfunction

  function void note_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
                         logic signed [15:0] vr);
    wheel_speeds_t   e;
    logic [31:0]     spd [4];
    longint          vxl;
    longint          vyl;
    longint          vrl;
    longint          dia;
    longint          rot;
    longint unsigned den;
    vxl = vx;
    vyl = vy;
    vrl = vr;
    dia = diameter;
    for (int w = 0; w < 4; w++) spd[w] = '0;
    if (radius != 0 && drive <= DRIVE_MECANUM) begin
      den = TWO_PI_Q16;
      den = den * radius;
      rot = dia * vrl * 128;
      for (int w = 0; w < 4; w++) begin
        if (drive != DRIVE_OMNI3 || w != WHL_BL) begin
          spd[w] = div_round_sat(x_gain(drive, w) * vxl + y_gain(drive, w) * vyl + rot, den);
        end
      end
    end
    e.fr    = spd[WHL_FR];
    e.fl    = spd[WHL_FL];
    e.br    = spd[WHL_BR];
    e.bl    = spd[WHL_BL];
    e.fault = (radius == 0);
    speeds_due.push_back(e);
  endfunction

  function void check_result(logic [31:0] fr, logic [31:0] fl, logic [31:0] br,
                             logic [31:0] bl, logic fault);
    wheel_speeds_t e;
    if (speeds_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected item: fr=%0d fl=%0d br=%0d bl=%0d fault=%0b",
                 $signed(fr), $signed(fl), $signed(br), $signed(bl), fault);
      return;
    end
    e = speeds_due.pop_front();
    if (fr !== e.fr || fl !== e.fl || br !== e.br || bl !== e.bl || fault !== e.fault) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected fr=%0d fl=%0d br=%0d bl=%0d fault=%0b",
                 $signed(e.fr), $signed(e.fl), $signed(e.br), $signed(e.bl), e.fault);
        $display("          actual   fr=%0d fl=%0d br=%0d bl=%0d fault=%0b",
                 $signed(fr), $signed(fl), $signed(br), $signed(bl), fault);
      end
    end
  endfunction

  function int pending();
    return speeds_due.size();
  endfunction
endclass

module tb;
  localparam int         LATENCY        = 38;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         BLOCK_ITEMS    = 86;
  localparam logic [1:0] DRIVE_UNUSED   = 2'd3;
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = CFG_DRIVE_TYPE;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_vel_x = '0;
  logic signed [15:0] in_vel_y = '0;
  logic signed [15:0] in_vel_rot = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] out_front_right;
  logic signed [31:0] out_front_left;
  logic signed [31:0] out_back_right;
  logic signed [31:0] out_back_left;
  logic               out_radius_fault;

  int tx_idle_pct = 30;
  int rx_idle_pct = 70;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  wheel_speed_board sb = new();

  omni_mecanum_wheel_speeds #(.IN_WIDTH(16)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_vel_rot       (in_vel_rot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_front_right  (out_front_right),
    .out_front_left   (out_front_left),
    .out_back_right   (out_back_right),
    .out_back_left    (out_back_left),
    .out_radius_fault (out_radius_fault)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_front_right, out_front_left, out_back_right, out_back_left,
                      out_radius_fault);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
                          logic signed [15:0] vr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_vel_x   <= vx;
    in_vel_y   <= vy;
    in_vel_rot <= vr;
    do @(posedge clk); while (in_stall);
    sb.note_cmd(vx, vy, vr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_vel();
    logic [15:0] v;
    case ($urandom_range(9))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'($urandom_range(512) - 256);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_config();
    logic [15:0] data;
    data = 16'($urandom);
    data[1:0] = ($urandom_range(9) == 0) ? DRIVE_UNUSED : 2'($urandom_range(2));
    cfg_write(CFG_DRIVE_TYPE, data);
    case ($urandom_range(9))
      0:       data = '0;
      1:       data = 16'($urandom_range(16, 1));
      2:       data = 16'hFFFF;
      default: data = 16'($urandom);
    endcase
    cfg_write(CFG_WHL_RAD, data);
    case ($urandom_range(9))
      0:       data = '0;
      1:       data = 16'hFFFF;
      default: data = 16'($urandom);
    endcase
    cfg_write(CFG_BASE_DIAM, data);
    if ($urandom_range(3) == 0) cfg_write(CFG_IDX_UNUSED, 16'($urandom));
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int blocks, bit squeeze);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (squeeze) hold_req = 1'b1;
    for (int b = 0; b < blocks; b++) begin
      random_config();
      for (int i = 0; i < BLOCK_ITEMS; i++) send_cmd(rand_vel(), rand_vel(), rand_vel());
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(16'h0000, 16'h0000, 16'h0000);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cmd(16'h8000, 16'h8000, 16'h8000);
    send_cmd(16'h7FFF, 16'h0000, 16'h0000);
    send_cmd(16'h0000, 16'h8000, 16'h0000);
    send_cmd(16'h0000, 16'h0000, 16'h7FFF);
    drain();

    // three-wheel, tiny radius: saturation
    cfg_write(CFG_DRIVE_TYPE, DRIVE_OMNI3);
    cfg_write(CFG_WHL_RAD, 16'h0001);
    cfg_write(CFG_BASE_DIAM, 16'hFFFF);
    send_cmd(16'h7FFF, 16'h8000, 16'h7FFF);
    send_cmd(16'h8000, 16'h7FFF, 16'h8000);
    send_cmd(16'h0100, 16'h0000, 16'h0000);
    send_cmd(16'h0000, 16'h0000, 16'h0001);
    drain();

    // zero radius: fault
    cfg_write(CFG_WHL_RAD, 16'h0000);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cmd(16'h1234, 16'hEDCB, 16'h0F0F);
    drain();

    // unused drive code
    cfg_write(CFG_WHL_RAD, 16'h0100);
    cfg_write(CFG_DRIVE_TYPE, DRIVE_UNUSED);
    send_cmd(16'h7FFF, 16'h8000, 16'h7FFF);
    send_cmd(16'h0100, 16'h0100, 16'h0100);
    drain();

    // mecanum through masked write, widest radius, no rotation arm, ignored index
    cfg_write(CFG_DRIVE_TYPE, 16'hFFFE);
    cfg_write(CFG_WHL_RAD, 16'hFFFF);
    cfg_write(CFG_BASE_DIAM, 16'h0000);
    cfg_write(CFG_IDX_UNUSED, 16'hFFFF);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cmd(16'h8000, 16'h8000, 16'h8000);
    send_cmd(16'h0001, 16'h0001, 16'h0001);
    send_cmd(16'h8000, 16'h7FFF, 16'h0000);
    drain();

    run_phase(30, 70, 4, 1'b0);
    run_phase(70, 30, 4, 1'b0);
    run_phase(0, 0, 4, 1'b1);

    repeat (2 * LATENCY) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
